// ===== rtl/core/tprf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprf_pkg
// Shared types and constants for the transformed printable-run finder.
// ----------------------------------------------------------------------------
package tprf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINLEN = 2'd2;

    localparam logic [1:0] KIND_ROTL  = 2'd0;
    localparam logic [1:0] KIND_ROTR  = 2'd1;
    localparam logic [1:0] KIND_SHIFT = 2'd2;
    localparam logic [1:0] KIND_XOR   = 2'd3;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic ITEM_CHAR = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HELD,
        ST_CHAR,
        ST_ENDM
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_HELD,
        SEL_CHAR,
        SEL_END
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_sel_t sel;
        logic     last;
    } tprf_cmd_t;

    typedef struct packed {
        logic go_held;
        logic go_char;
        logic go_end;
        logic held_done;
        logic eod;
        logic out_free;
    } tprf_status_t;

endpackage

// ===== rtl/core/tprf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprf_ctrl
// Sequencer: accepts an item, then steps the output register through held
// characters, the current character and the run-end mark.
// ----------------------------------------------------------------------------
module tprf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tprf_pkg::tprf_status_t status,
    output tprf_pkg::tprf_cmd_t    cmd
);
    import tprf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (status.go_held) state_next = ST_HELD;
                    else if (status.go_char)     state_next = ST_CHAR;
                    else if (status.go_end)      state_next = ST_ENDM;
                    else                         state_next = ST_IDLE;
                end
            end
            ST_HELD:
            begin
                if (status.out_free && status.held_done)
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (status.out_free)
                begin
                    state_next = status.eod ? ST_ENDM : ST_IDLE;
                end
            end
            ST_ENDM:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.sel    = SEL_CHAR;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_HELD:
            begin
                cmd.load = status.out_free;
                cmd.sel  = SEL_HELD;
            end
            ST_CHAR:
            begin
                cmd.load = status.out_free;
                cmd.sel  = SEL_CHAR;
                cmd.last = !status.eod;
            end
            ST_ENDM:
            begin
                cmd.load = status.out_free;
                cmd.sel  = SEL_END;
                cmd.last = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tprf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprf_datapath
// Config registers, byte transform, run tracking, held-character file and
// output register.
// ----------------------------------------------------------------------------
module tprf_datapath #(
    parameter int RUN_LEN_CAP = 16,
    parameter int POS_WIDTH   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tprf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tprf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [tprf_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    input  logic                               m_tready,
    input  tprf_pkg::tprf_cmd_t                cmd,
    output tprf_pkg::tprf_status_t             status,
    output logic                               m_tvalid,
    output logic [tprf_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import tprf_pkg::*;

    localparam int MW     = $clog2(RUN_LEN_CAP + 1);
    localparam int HDEPTH = RUN_LEN_CAP - 1;
    localparam int HIDX_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

    logic [1:0]           kind_reg;
    logic [7:0]           amount_reg;
    logic [4:0]           minlen_reg;

    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [MW-1:0]        rc_reg, rc_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;
    logic                 printing_reg, printing_next;
    logic                 found_reg, found_next;
    logic [7:0]           held_reg [HDEPTH];

    logic [7:0]           ch_reg;
    logic                 eod_reg;
    logic                 first_reg;
    logic                 cfirst_reg;
    logic [POS_WIDTH-1:0] bstart_reg;
    logic [HIDX_W-1:0]    idx_reg;

    logic                 ovalid_reg;
    logic                 okind_reg;
    logic [7:0]           ochar_reg;
    logic [31:0]          ostart_reg;
    logic                 ofirstc_reg;
    logic                 ofirstr_reg;
    logic                 olast_reg;

    logic [7:0]           b, nb, ch;
    logic [2:0]           k;
    logic [15:0]          rotl_w, rotr_w, shl_w;
    logic                 printable;
    logic [MW-1:0]        m_eff;
    logic [MW-1:0]        rc_inc;
    logic                 qualify;
    logic                 held_wr;
    logic [63:0]          bstart_ext;

    assign b  = s_tdata[7:0];
    assign nb = s_tdata[15:8];
    assign k  = amount_reg[2:0];

    assign rotl_w = {b, b} << k;
    assign rotr_w = {b, b} >> k;
    assign shl_w  = {b, nb} << k;

    always_comb
    begin
        if (kind_reg == KIND_XOR)
        begin
            ch = b ^ amount_reg;
        end
        else if (amount_reg == 8'd0 || amount_reg > 8'd7)
        begin
            ch = b;
        end
        else
        begin
            unique case (kind_reg)
                KIND_ROTL:  ch = rotl_w[15:8];
                KIND_ROTR:  ch = rotr_w[7:0];
                KIND_SHIFT: ch = shl_w[15:8];
                default:    ch = b;
            endcase
        end
    end

    always_comb
    begin
        if (minlen_reg == 5'd0)
        begin
            m_eff = MW'(1);
        end
        else if (int'(minlen_reg) > RUN_LEN_CAP)
        begin
            m_eff = MW'(RUN_LEN_CAP);
        end
        else
        begin
            m_eff = MW'(minlen_reg);
        end
    end

    assign printable = (ch >= PRINT_LO) && (ch <= PRINT_HI);
    assign rc_inc    = rc_reg + MW'(1);
    assign qualify   = printable && !printing_reg && (rc_inc >= m_eff);

    // run state update for an accepted item
    always_comb
    begin
        pos_next      = pos_reg;
        rc_next       = rc_reg;
        start_next    = start_reg;
        printing_next = printing_reg;
        found_next    = found_reg;
        held_wr       = 1'b0;
        if (cmd.accept)
        begin
            if (!printable)
            begin
                if (printing_reg)
                begin
                    found_next = 1'b1;
                end
                printing_next = 1'b0;
                rc_next       = '0;
            end
            else if (!printing_reg)
            begin
                if (rc_reg == '0)
                begin
                    start_next = pos_reg;
                end
                rc_next = rc_inc;
                if (rc_inc < m_eff)
                begin
                    held_wr = 1'b1;
                end
                else
                begin
                    printing_next = 1'b1;
                end
            end
            if (s_tlast)
            begin
                if (printing_next)
                begin
                    found_next = 1'b1;
                end
                pos_next      = '0;
                rc_next       = '0;
                start_next    = '0;
                printing_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_ROTL;
            amount_reg   <= 8'd1;
            minlen_reg   <= 5'd3;
            pos_reg      <= '0;
            rc_reg       <= '0;
            start_reg    <= '0;
            printing_reg <= 1'b0;
            found_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KIND:   kind_reg   <= cfg_data[1:0];
                    CFG_AMOUNT: amount_reg <= cfg_data;
                    CFG_MINLEN: minlen_reg <= cfg_data[4:0];
                    default:    kind_reg   <= kind_reg;
                endcase
            end
            pos_reg      <= pos_next;
            rc_reg       <= rc_next;
            start_reg    <= start_next;
            printing_reg <= printing_next;
            found_reg    <= found_next;
            if (cmd.load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (held_wr)
        begin
            held_reg[rc_reg[HIDX_W-1:0]] <= ch;
        end
        if (cmd.accept)
        begin
            ch_reg     <= ch;
            eod_reg    <= s_tlast;
            first_reg  <= !found_reg;
            cfirst_reg <= qualify && (m_eff == MW'(1));
            if (printable && !printing_reg && rc_reg == '0)
            begin
                bstart_reg <= pos_reg;
            end
            else
            begin
                bstart_reg <= start_reg;
            end
            idx_reg    <= '0;
        end
        else if (cmd.load && cmd.sel == SEL_HELD)
        begin
            idx_reg <= idx_reg + HIDX_W'(1);
        end
        if (cmd.load)
        begin
            ostart_reg  <= bstart_ext[31:0];
            ofirstr_reg <= first_reg;
            olast_reg   <= cmd.last;
            unique case (cmd.sel)
                SEL_HELD:
                begin
                    okind_reg   <= ITEM_CHAR;
                    ochar_reg   <= held_reg[idx_reg];
                    ofirstc_reg <= (idx_reg == '0);
                end
                SEL_CHAR:
                begin
                    okind_reg   <= ITEM_CHAR;
                    ochar_reg   <= ch_reg;
                    ofirstc_reg <= cfirst_reg;
                end
                SEL_END:
                begin
                    okind_reg   <= ITEM_END;
                    ochar_reg   <= 8'd0;
                    ofirstc_reg <= 1'b0;
                end
                default:
                begin
                    okind_reg   <= ITEM_END;
                    ochar_reg   <= 8'd0;
                    ofirstc_reg <= 1'b0;
                end
            endcase
        end
    end

    assign bstart_ext = 64'(bstart_reg);

    assign status.go_held   = qualify && (m_eff > MW'(1));
    assign status.go_char   = printable && (printing_reg || qualify);
    assign status.go_end    = !printable && printing_reg;
    assign status.held_done = ({1'b0, MW'(idx_reg)} == ({1'b0, m_eff} - (MW + 1)'(2)));
    assign status.eod       = eod_reg;
    assign status.out_free  = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {6'd0, ofirstr_reg, ofirstc_reg, ostart_reg, ochar_reg};

endmodule

// ===== rtl/core/transformed_printable_run_finder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_printable_run_finder_top
// Byte transform plus printable-run extraction with held-character burst.
// ----------------------------------------------------------------------------
// An item that causes no result leaves the sequencer idle, and the input stays
// ready. For an item that causes results, the sequencer loads the single
// output register once per cycle while the output side does not stall, first
// with the held characters of a newly qualified run (read one per cycle from
// the held-character register file), then with the current character, then
// with the run-end mark. Input is not taken while that sequence runs. Config
// writes are registered, with no read-back.
module transformed_printable_run_finder_top #(
    parameter int RUN_LEN_CAP = 16,
    parameter int POS_WIDTH   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tprf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tprf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tprf_pkg::S_DATA_W-1:0]   s_tdata,   // byte_in, next_byte
    input  logic                            s_tlast,   // end_of_data
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // char_out, run_start, run_first_char, first_run_of_pass, zero pad
    output logic [tprf_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,   // item_kind
    output logic                            m_tlast    // last_of_burst
);
    import tprf_pkg::*;

    tprf_cmd_t    cmd;
    tprf_status_t status;

    tprf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tprf_datapath #(
        .RUN_LEN_CAP (RUN_LEN_CAP),
        .POS_WIDTH   (POS_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/tprf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprf_checker
// Port-level checks for the run finder, bound to the top level.
// ----------------------------------------------------------------------------
module tprf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tprf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import tprf_pkg::*;

    // stalled transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    // run-end mark always closes the burst
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ITEM_END) |-> m_tlast)
        else $error("run-end mark not last of burst");

    // run-end mark carries no character and no first-char flag
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ITEM_END) |-> (m_tdata[7:0] == 8'd0) && !m_tdata[40])
        else $error("run-end mark payload not clear");

    // no new input taken while a burst is in progress
    a_burst_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during burst");

endmodule

bind transformed_printable_run_finder_top tprf_checker u_chk (.*);

// ===== tb/transformed_printable_run_finder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_printable_run_finder_top_tb
// Self-checking bench for the transformed printable-run finder. A directed
// table covers reset state, every transform kind, pass-through amounts, the
// minimum-length clamps, a minimum lowered mid-run and the longest burst. It
// is followed by random byte blocks under changing register settings. Every
// output transfer is checked against the run predictor or a table entry.
// ----------------------------------------------------------------------------
module transformed_printable_run_finder_top_tb;

    import tprf_pkg::*;

    localparam int MAX_LEN     = 16;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 110;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [31:0] start;
        logic        first_char;
        logic        first_run;
        logic        last;
    } run_item_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

    // cfg rows: b is the write data, nb[1:0] the register index
    typedef struct packed {
        row_op_t   op;
        logic [7:0] b;
        logic [7:0] nb;
        logic       eod;
        logic [4:0] rep;
        chk_t       chk;
        run_item_t  want;
    } dir_row_t;

    localparam run_item_t NO_ITEM = '0;
    localparam int N_ROWS = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // register shadows
    logic [1:0] cfg_kind;
    logic [7:0] cfg_amount;
    logic [4:0] cfg_minlen;

    // predictor state
    logic [31:0] byte_pos;
    int          run_len;
    logic [31:0] run_off;
    logic        printing;
    logic        found_any;
    logic [7:0]  held [MAX_LEN];

    run_item_t step_items [$];
    run_item_t run_items_due [$];
    run_item_t got_item;
    run_item_t want_item;

    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    dir_row_t dir_rows [N_ROWS];

    transformed_printable_run_finder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [7:0] xform(input logic [7:0] b, input logic [7:0] nb);
        int k;
        k = cfg_amount;
        if (cfg_kind == KIND_XOR)
            return b ^ cfg_amount;
        if (k == 0 || k > 7)
            return b;
        case (cfg_kind)
            KIND_ROTL: return (b << k) | (b >> (8 - k));
            KIND_ROTR: return (b >> k) | (b << (8 - k));
            default:   return (b << k) | (nb >> (8 - k));
        endcase
    endfunction

    // raw byte that transforms to c (stream shift: top bits random)
    function automatic logic [7:0] raw_for(input logic [7:0] c);
        int         k;
        logic [7:0] fill;
        k = cfg_amount;
        fill = 8'($urandom_range(0, 255));
        if (cfg_kind == KIND_XOR)
            return c ^ cfg_amount;
        if (k == 0 || k > 7)
            return c;
        case (cfg_kind)
            KIND_ROTL: return (c >> k) | (c << (8 - k));
            KIND_ROTR: return (c << k) | (c >> (8 - k));
            default:   return (c >> k) | (fill << (8 - k));
        endcase
    endfunction

    function automatic run_item_t mk_item(input logic kind, input logic [7:0] ch,
                                          input logic first_char, input logic first_run);
        run_item_t r;
        r.kind       = kind;
        r.ch         = ch;
        r.start      = run_off;
        r.first_char = first_char;
        r.first_run  = first_run;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic find_runs_step(input logic [7:0] b, input logic [7:0] nb,
                                  input logic eod);
        logic [7:0] ch;
        logic       first;
        int         m;
        ch = xform(b, nb);
        first = !found_any;
        m = cfg_minlen;
        step_items.delete();
        if (m == 0)
            m = 1;
        if (m > MAX_LEN)
            m = MAX_LEN;
        if (ch < PRINT_LO || ch > PRINT_HI)
        begin
            if (printing)
            begin
                step_items.push_back(mk_item(ITEM_END, 8'h00, 1'b0, first));
                found_any = 1'b1;
                printing = 1'b0;
            end
            run_len = 0;
        end
        else if (printing)
        begin
            step_items.push_back(mk_item(ITEM_CHAR, ch, 1'b0, first));
        end
        else
        begin
            if (run_len == 0)
                run_off = byte_pos;
            run_len++;
            if (run_len < m)
                held[run_len - 1] = ch;
            else
            begin
                for (int i = 0; i + 1 < m; i++)
                    step_items.push_back(mk_item(ITEM_CHAR, held[i], i == 0, first));
                step_items.push_back(mk_item(ITEM_CHAR, ch, m == 1, first));
                printing = 1'b1;
            end
        end
        if (eod)
        begin
            if (printing)
            begin
                step_items.push_back(mk_item(ITEM_END, 8'h00, 1'b0, first));
                found_any = 1'b1;
            end
            byte_pos = '0;
            run_len = 0;
            run_off = '0;
            printing = 1'b0;
        end
        else
            byte_pos = byte_pos + 1;
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
    endtask

    task automatic send_item(input logic [7:0] b, input logic [7:0] nb, input logic eod,
                             input chk_t chk, input run_item_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nb, b};
        s_tlast  <= eod;
        do
            @(posedge clk);
        while (!s_tready);
        find_runs_step(b, nb, eod);
        items_sent++;
        case (chk)
            CHK_MODEL: foreach (step_items[i]) run_items_due.push_back(step_items[i]);
            CHK_ONE:   run_items_due.push_back(want);
            default:   ;
        endcase
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        while (run_items_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        hold_off();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_KIND:   cfg_kind = val[1:0];
            CFG_AMOUNT: cfg_amount = val;
            CFG_MINLEN: cfg_minlen = val[4:0];
            default:    ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [1:0] kind;
        logic [7:0] amount;
        logic [7:0] minlen;
        int         r;
        kind = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        if (kind == KIND_XOR)
            amount = 8'($urandom_range(0, 255));
        else if (r == 0)
            amount = 8'h00;
        else if (r == 1)
            amount = 8'($urandom_range(8, 255));
        else
            amount = 8'($urandom_range(1, 7));
        r = $urandom_range(0, 11);
        if (r == 0)
            minlen = 8'h00;
        else if (r == 1)
            minlen = 8'($urandom_range(16, 31));
        else
            minlen = 8'($urandom_range(1, 6));
        write_reg(CFG_KIND, {6'd0, kind});
        write_reg(CFG_AMOUNT, amount);
        write_reg(CFG_MINLEN, {3'($urandom_range(0, 7)), minlen[4:0]});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_block(input bit noise);
        logic [7:0] raw [$];
        logic [7:0] c;
        logic [7:0] nb;
        int         len;
        int         r;
        bit         close;
        len = $urandom_range(1, 40);
        close = ($urandom_range(0, 5) != 0);
        if (noise)
        begin
            repeat (len)
                send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) == 0, CHK_MODEL, NO_ITEM);
        end
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    c = 8'($urandom_range(PRINT_LO, PRINT_HI));
                else if (r < 91)
                    c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h1F))
                                                   : 8'($urandom_range(8'h7F, 8'hFF));
                else
                    c = 8'($urandom_range(0, 255));
                raw.push_back((r < 91) ? raw_for(c) : c);
            end
            for (int i = 0; i < len; i++)
            begin
                if (i + 1 < len)
                    nb = raw[i + 1];
                else
                    nb = close ? 8'h00 : 8'($urandom_range(0, 255));
                send_item(raw[i], nb, close && (i == len - 1), CHK_MODEL, NO_ITEM);
                if (i == len / 2 && $urandom_range(0, 9) == 0)
                    hold_off();
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_item.kind       = m_tuser;
            got_item.ch         = m_tdata[7:0];
            got_item.start      = m_tdata[39:8];
            got_item.first_char = m_tdata[40];
            got_item.first_run  = m_tdata[41];
            got_item.last       = m_tlast;
            if (run_items_due.size() == 0)
            begin
                $display("%0t ns: unexpected output transfer, expected none, actual %h",
                         $time, got_item);
                errors++;
            end
            else
            begin
                want_item = run_items_due.pop_front();
                check_field("item_kind", 32'(want_item.kind), 32'(got_item.kind));
                check_field("char_out", 32'(want_item.ch), 32'(got_item.ch));
                check_field("run_start", want_item.start, got_item.start);
                check_field("run_first_char", 32'(want_item.first_char),
                            32'(got_item.first_char));
                check_field("first_run_of_pass", 32'(want_item.first_run),
                            32'(got_item.first_run));
                check_field("last_of_burst", 32'(want_item.last), 32'(got_item.last));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;

        cfg_kind   = KIND_ROTL;
        cfg_amount = 8'd1;
        cfg_minlen = 5'd3;
        byte_pos   = '0;
        run_len    = 0;
        run_off    = '0;
        printing   = 1'b0;
        found_any  = 1'b0;
        foreach (held[i]) held[i] = 8'h00;

        dir_rows = '{
            '{ROW_ITEM, 8'h00, 8'h10, 1'b0, 5'd1, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h10, 8'h3F, 1'b0, 5'd1, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h3F, 8'h20, 1'b0, 5'd1, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h20, 8'h21, 1'b0, 5'd1, CHK_MODEL, NO_ITEM},
            '{ROW_ITEM, 8'h21, 8'hBF, 1'b0, 5'd1, CHK_ONE,
              '{ITEM_CHAR, 8'h42, 32'd1, 1'b0, 1'b1, 1'b1}},
            '{ROW_ITEM, 8'hBF, 8'hFF, 1'b0, 5'd1, CHK_ONE,
              '{ITEM_END, 8'h00, 32'd1, 1'b0, 1'b1, 1'b1}},
            '{ROW_ITEM, 8'hFF, 8'hFF, 1'b1, 5'd1, CHK_NONE, NO_ITEM},
            '{ROW_CFG, {6'd0, KIND_SHIFT}, {6'd0, CFG_KIND}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd3, {6'd0, CFG_AMOUNT}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h0C, 8'hFF, 1'b0, 5'd1, CHK_MODEL, NO_ITEM},
            '{ROW_ITEM, 8'hFF, 8'h00, 1'b0, 5'd1, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd0, {6'd0, CFG_AMOUNT}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd0, {6'd0, CFG_MINLEN}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h41, 8'h7E, 1'b0, 5'd1, CHK_ONE,
              '{ITEM_CHAR, 8'h41, 32'd2, 1'b1, 1'b0, 1'b1}},
            '{ROW_ITEM, 8'h7E, 8'h00, 1'b1, 5'd1, CHK_MODEL, NO_ITEM},
            '{ROW_CFG, {6'd0, KIND_XOR}, {6'd0, CFG_KIND}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'hFF, {6'd0, CFG_AMOUNT}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd31, {6'd0, CFG_MINLEN}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'hBE, 8'hBE, 1'b0, 5'd15, CHK_MODEL, NO_ITEM},
            '{ROW_ITEM, 8'hBE, 8'h00, 1'b1, 5'd1, CHK_MODEL, NO_ITEM},
            '{ROW_CFG, 8'd8, {6'd0, CFG_MINLEN}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'hDF, 8'hDF, 1'b0, 5'd5, CHK_MODEL, NO_ITEM},
            '{ROW_CFG, 8'd3, {6'd0, CFG_MINLEN}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd0, {6'd0, CFG_AMOUNT}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'hFF, {6'd0, CFG_SPARE}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'h7E, 8'h7F, 1'b0, 5'd1, CHK_MODEL, NO_ITEM},
            '{ROW_ITEM, 8'h7F, 8'h00, 1'b1, 5'd1, CHK_ONE,
              '{ITEM_END, 8'h00, 32'd0, 1'b0, 1'b0, 1'b1}},
            '{ROW_CFG, {6'd0, KIND_ROTR}, {6'd0, CFG_KIND}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_CFG, 8'd9, {6'd0, CFG_AMOUNT}, 1'b0, 5'd0, CHK_NONE, NO_ITEM},
            '{ROW_ITEM, 8'hFF, 8'hFF, 1'b1, 5'd1, CHK_NONE, NO_ITEM}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 53;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CFG)
                write_reg(dir_rows[i].nb[CFG_IDX_W-1:0], dir_rows[i].b);
            else
                repeat (dir_rows[i].rep)
                    send_item(dir_rows[i].b, dir_rows[i].nb, dir_rows[i].eod,
                              dir_rows[i].chk, dir_rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            int start_count;
            start_count = items_sent;
            case (ph)
                0:       begin send_idle_pct = 10; recv_idle_pct = 53; end
                1:       begin send_idle_pct = 53; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                random_config();
                repeat ($urandom_range(1, 3))
                    send_block($urandom_range(0, 9) == 0);
            end
        end

        s_tvalid <= 1'b0;
        while (run_items_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tprf_pkg.sv
rtl/core/tprf_ctrl.sv
rtl/core/tprf_datapath.sv
rtl/core/transformed_printable_run_finder_top.sv
rtl/core/tprf_checker.sv
tb/transformed_printable_run_finder_top_tb.sv
